@@ rtl/core/rdc_pkg.sv @@
// Shared types, constants and a helper function for the radix digit converter.
`timescale 1ns / 1ps

package rdc_pkg;

	// Field widths of the input and result items.
	localparam int VALUE_W = 31;
	localparam int RADIX_W = 5;
	localparam int DIGIT_W = 4;
	localparam int CHAR_W  = 7;

	// Digit stack geometry.
	localparam int STACK_DEPTH = 32;
	localparam int PTR_W       = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	// Divider geometry: the dividend is walked eight bits per cycle.
	localparam int WORK_W    = 32;
	localparam int CHUNK_W   = 8;
	localparam int DIV_STEPS = WORK_W / CHUNK_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	// Legal base range.
	localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

	// Character codes.
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
	localparam logic [CHAR_W-1:0] CHAR_A     = CHAR_W'(65);
	localparam logic [DIGIT_W-1:0] DIGIT_TEN = DIGIT_W'(10);

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_READ,
		ST_SHOW
	} state_t;

	// Request from the sequencer to the shared divider.
	typedef struct packed {
		logic               start;
		logic [RADIX_W-1:0] base;
		logic [VALUE_W-1:0] dividend;
	} div_req_t;

	// Response from the shared divider.
	typedef struct packed {
		logic               done;
		logic [VALUE_W-1:0] quotient;
		logic [DIGIT_W-1:0] remainder;
	} div_rsp_t;

	// Maps a digit value onto its ASCII character.
	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DIGIT_TEN) begin
			c = CHAR_ZERO + CHAR_W'(d);
		end else begin
			c = CHAR_A + CHAR_W'(d - DIGIT_TEN);
		end
		return c;
	endfunction

endpackage

@@ rtl/core/rdc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module rdc_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/rdc_div.sv @@
// Iterative divider by a narrow base, eight quotient bits per cycle.
`timescale 1ns / 1ps

module rdc_div
	import rdc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   step_q;
	logic [WORK_W-1:0]   work_q;
	logic [DIGIT_W-1:0]  rem_q;
	logic [RADIX_W-1:0]  base_q;
	logic [CHUNK_W-1:0]  qbits;
	logic [DIGIT_W:0]    rem_nxt;

	// One chunk of restoring long division: the partial remainder stays below the base.
	always_comb begin
		logic [DIGIT_W:0] r;
		r     = {1'b0, rem_q};
		qbits = '0;
		for (int i = 0; i < CHUNK_W; i++) begin
			r = {r[DIGIT_W-1:0], work_q[WORK_W-1-i]};
			if (r >= (DIGIT_W+1)'(base_q)) begin
				r                  = r - (DIGIT_W+1)'(base_q);
				qbits[CHUNK_W-1-i] = 1'b1;
			end
		end
		rem_nxt = r;
	end

	// Control state of the divider.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Working registers: the dividend shifts out as the quotient shifts in.
	always_ff @(posedge clk) begin
		if (req.start) begin
			work_q <= WORK_W'(req.dividend);
			rem_q  <= '0;
			base_q <= req.base;
		end else if (busy_q) begin
			work_q <= {work_q[WORK_W-CHUNK_W-1:0], qbits};
			rem_q  <= rem_nxt[DIGIT_W-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = work_q[VALUE_W-1:0];
	assign rsp.remainder = rem_q;

endmodule

@@ rtl/core/radix_digit_converter_unit.sv @@
// Top level of the radix digit converter: sequencer, digit stack and divider.
`timescale 1ns / 1ps

// Converts a non-negative integer into its digit string in a base from 2 to 16.
// Input channel (src_valid, src_stall, value, radix): one item per conversion.
// A radix below 2 is treated as 2 and one above 16 as 16.
// Output channel (digit_valid, digit_stall, digit_char, last): one item per
// digit, most significant first, as ASCII '0'..'9' or 'A'..'F'; last marks the
// final, least significant digit. A value of zero gives a single '0'.
// src_stall is high from the accepted item until its last digit is taken, so
// the block works on one conversion at a time.
// Each digit costs four eight-bit steps in the shared divider and a hand-over
// of the result; all digits are divided first, then each digit is read from
// the stack memory and presented in turn.
// While digit_stall is high the digit on the outputs holds and the sequencer
// waits. Reset returns the sequencer to idle with an empty stack; the stack
// memory itself is not cleared, as only freshly pushed digits are ever read.
module radix_digit_converter_unit
	import rdc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  logic [VALUE_W-1:0] value,
	input  logic [RADIX_W-1:0] radix,
	output logic               digit_valid,
	input  logic               digit_stall,
	output logic [CHAR_W-1:0]  digit_char,
	output logic               last
);

	state_t              state_q;
	state_t              state_nxt;
	logic [CNT_W-1:0]    cnt_q;
	logic [RADIX_W-1:0]  base_q;
	logic [RADIX_W-1:0]  base_clamped;
	logic                accept;
	logic                push;
	logic                rd_en;
	logic [DIGIT_W-1:0]  rd_digit;
	div_req_t            div_req;
	div_rsp_t            div_rsp;

	// Bring the requested base into the legal range.
	always_comb begin
		if (radix < RADIX_MIN) begin
			base_clamped = RADIX_MIN;
		end else if (radix > RADIX_MAX) begin
			base_clamped = RADIX_MAX;
		end else begin
			base_clamped = radix;
		end
	end

	assign accept = src_valid && !src_stall;

	// Next state and sequencer outputs.
	always_comb begin
		state_nxt        = state_q;
		src_stall        = (state_q != ST_IDLE);
		push             = 1'b0;
		rd_en            = 1'b0;
		div_req.start    = 1'b0;
		div_req.base     = base_q;
		div_req.dividend = div_rsp.quotient;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					div_req.start    = 1'b1;
					div_req.base     = base_clamped;
					div_req.dividend = value;
					state_nxt        = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					push = (cnt_q < CNT_W'(STACK_DEPTH));
					if (div_rsp.quotient != '0) begin
						div_req.start = 1'b1;
					end else begin
						state_nxt = ST_READ;
					end
				end
			end
			ST_READ: begin
				rd_en     = 1'b1;
				state_nxt = ST_SHOW;
			end
			ST_SHOW: begin
				if (!digit_stall) begin
					state_nxt = (cnt_q == '0) ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Stack fill count and the base in use.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			base_q <= RADIX_MIN;
		end else if (accept) begin
			cnt_q  <= '0;
			base_q <= base_clamped;
		end else if (push) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (rd_en) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Digit stack.
	rdc_ram #(
		.WIDTH(DIGIT_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (push),
		.waddr (cnt_q[PTR_W-1:0]),
		.wdata (div_rsp.remainder),
		.re    (rd_en),
		.raddr (PTR_W'(cnt_q - 1'b1)),
		.rdata (rd_digit)
	);

	// Shared divider.
	rdc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Result item.
	assign digit_valid = (state_q == ST_SHOW);
	assign digit_char  = digit_to_ascii(rd_digit);
	assign last        = (cnt_q == '0);

endmodule

@@ rtl/core/rdc_checker.sv @@
// Port-level checker for the radix digit converter and its bind statement.
`timescale 1ns / 1ps

module rdc_checker
	import rdc_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               src_valid,
	input logic               src_stall,
	input logic [VALUE_W-1:0] value,
	input logic [RADIX_W-1:0] radix,
	input logic               digit_valid,
	input logic               digit_stall,
	input logic [CHAR_W-1:0]  digit_char,
	input logic               last
);

	// A waiting input item is not withdrawn.
	assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && src_stall |=> src_valid)
		else $error("input item withdrawn while stalled");

	// A stalled digit holds its value and its end mark.
	assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid && digit_stall |=> digit_valid && $stable(digit_char) && $stable(last))
		else $error("stalled digit changed");

	// No new item is taken while digits of the current one are on offer.
	assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid |-> src_stall)
		else $error("input accepted during digit output");

	// An accepted item needs at least one division before its first digit.
	assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && !src_stall |=> !digit_valid && src_stall)
		else $error("digit shown straight after accept");

	// Every digit is a legal character.
	assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid |-> (digit_char >= CHAR_W'(48) && digit_char <= CHAR_W'(57)) ||
			(digit_char >= CHAR_W'(65) && digit_char <= CHAR_W'(70)))
		else $error("digit character out of range");

endmodule

bind radix_digit_converter_unit rdc_checker u_rdc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.src_valid   (src_valid),
	.src_stall   (src_stall),
	.value       (value),
	.radix       (radix),
	.digit_valid (digit_valid),
	.digit_stall (digit_stall),
	.digit_char  (digit_char),
	.last        (last)
);
